@@ hw/rtl/clc_pkg.sv @@
// Types, character codes and per-byte cleaning functions for the line cleaner.
package clc_pkg;

    localparam int MAX_RES = 3;
    localparam int CNT_W   = $clog2(MAX_RES + 1);

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [1:0] HELD_NONE  = 2'd0;
    localparam logic [1:0] HELD_SLASH = 2'd1;
    localparam logic [1:0] HELD_STAR  = 2'd2;

    typedef logic [CNT_W-1:0] t_cnt;

    typedef struct packed {
        logic       stream_done;
        logic       bad_line;
        logic       line_end;
        logic       is_char;
        logic [7:0] out_char;
    } t_res;

    typedef struct packed {
        logic       inside_comment;
        logic       after_space;
        logic       space_pending;
        logic [1:0] held_kind;
        logic       line_has_output;
        logic       hash_suppress;
        logic       line_error;
        logic       skip_after_cr;
    } t_state;

    localparam t_state STATE_RST = '{
        inside_comment:  1'b0,
        after_space:     1'b1,
        space_pending:   1'b0,
        held_kind:       HELD_NONE,
        line_has_output: 1'b0,
        hash_suppress:   1'b0,
        line_error:      1'b0,
        skip_after_cr:   1'b0
    };

    typedef struct packed {
        t_state                   st;
        t_res [MAX_RES-1:0]       res;
        t_cnt                     cnt;
    } t_step;

    function automatic t_step f_put(t_step s, logic [7:0] ch, logic isc, logic le, logic bad);
        t_step r;
        r = s;
        if (r.cnt < t_cnt'(MAX_RES)) begin
            r.res[r.cnt[CNT_W-1:0]] = '{stream_done: 1'b0, bad_line: bad, line_end: le,
                                        is_char: isc, out_char: ch};
            r.cnt = r.cnt + t_cnt'(1);
        end
        return r;
    endfunction

    function automatic t_step f_keep(t_step s, logic [7:0] c);
        t_step r;
        r = s;
        if (!r.st.line_has_output) begin
            r.st.line_has_output = 1'b1;
            if (c == CH_HASH) begin
                r.st.hash_suppress = 1'b1;
            end
        end
        if (!r.st.hash_suppress) begin
            if (r.st.space_pending) begin
                r = f_put(r, CH_SPACE, 1'b1, 1'b0, 1'b0);
            end
            r = f_put(r, c, 1'b1, 1'b0, 1'b0);
        end
        r.st.space_pending = 1'b0;
        r.st.after_space   = 1'b0;
        return r;
    endfunction

    function automatic t_step f_plain(t_step s, logic [7:0] c);
        t_step r;
        r = s;
        if (!r.st.inside_comment) begin
            if (c == CH_SPACE || c == CH_TAB) begin
                if (!r.st.after_space) begin
                    r.st.after_space   = 1'b1;
                    r.st.space_pending = 1'b1;
                end
            end else begin
                r = f_keep(r, c);
            end
        end
        return r;
    endfunction

    function automatic t_step f_fresh(t_step s, logic [7:0] b);
        t_step r;
        r = s;
        if (b == CH_SLASH) begin
            r.st.held_kind = HELD_SLASH;
        end else if (b == CH_STAR) begin
            r.st.held_kind = HELD_STAR;
        end else begin
            r = f_plain(r, b);
        end
        return r;
    endfunction

    function automatic logic [7:0] f_held_char(logic [1:0] h);
        return (h == HELD_STAR) ? CH_STAR : CH_SLASH;
    endfunction

    function automatic t_step f_take(t_step s, logic [7:0] b);
        t_step      r;
        logic [1:0] h;
        r = s;
        h = r.st.held_kind;
        if (h == HELD_NONE) begin
            r = f_fresh(r, b);
        end else begin
            r.st.held_kind = HELD_NONE;
            if (h == HELD_SLASH && b == CH_STAR) begin
                r.st.inside_comment = 1'b1;
            end else if (h == HELD_STAR && b == CH_SLASH) begin
                if (r.st.inside_comment) begin
                    r.st.inside_comment = 1'b0;
                end else begin
                    r.st.line_error = 1'b1;
                end
            end else begin
                r = f_plain(r, f_held_char(h));
                r = f_fresh(r, b);
            end
        end
        return r;
    endfunction

    function automatic t_step f_close(t_step s);
        t_step r;
        logic  skip;
        r = s;
        if (!r.st.line_error && r.st.held_kind != HELD_NONE) begin
            r.st.held_kind = HELD_NONE;
            r = f_plain(r, f_held_char(s.st.held_kind));
        end
        if (r.st.inside_comment) begin
            r.st.line_error = 1'b1;
        end
        if (r.st.line_error) begin
            r = f_put(r, CH_NUL, 1'b0, 1'b1, 1'b1);
        end else if (r.st.line_has_output && !r.st.hash_suppress) begin
            r = f_put(r, CH_NUL, 1'b0, 1'b1, 1'b0);
        end
        skip = r.st.skip_after_cr;
        r.st = STATE_RST;
        r.st.skip_after_cr = skip;
        return r;
    endfunction

    function automatic t_step f_step(t_state st, logic [7:0] b, logic fin);
        t_step r;
        r.st  = st;
        r.res = '0;
        r.cnt = '0;
        if (fin) begin
            r = f_close(r);
            if (r.cnt == '0) begin
                r = f_put(r, CH_NUL, 1'b0, 1'b0, 1'b0);
            end
            r.res[r.cnt - t_cnt'(1)].stream_done = 1'b1;
            r.st = STATE_RST;
        end else if (r.st.skip_after_cr) begin
            r.st.skip_after_cr = 1'b0;
        end else if (b == CH_LF || b == CH_CR) begin
            r = f_close(r);
            if (b == CH_CR) begin
                r.st.skip_after_cr = 1'b1;
            end
        end else if (!r.st.line_error) begin
            r = f_take(r, b);
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/clc_out_buf.sv @@
// Result buffer: holds up to three results of one byte and sends them one per transfer.
module clc_out_buf
    import clc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  t_cnt                   i_cnt,
    input  t_res [MAX_RES-1:0]     i_res,
    output logic                   o_ready,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [7:0]             o_m_tdata,   // out_char
    output logic                   o_m_tlast,   // line_end
    output logic [2:0]             o_m_tuser    // is_char, bad_line, stream_done
);

    t_res [MAX_RES-1:0] r_res;
    t_res [MAX_RES-1:0] n_res;
    t_cnt               r_cnt;
    t_cnt               n_cnt;
    logic               pop;

    assign o_m_tvalid = (r_cnt != '0);
    assign pop        = o_m_tvalid && i_m_tready;
    assign o_ready    = (r_cnt == '0) || (r_cnt == t_cnt'(1) && i_m_tready);

    assign o_m_tdata  = r_res[0].out_char;
    assign o_m_tlast  = r_res[0].line_end;
    assign o_m_tuser  = {r_res[0].stream_done, r_res[0].bad_line, r_res[0].is_char};

    always_comb begin
        n_res = r_res;
        n_cnt = r_cnt;
        if (i_load) begin
            n_res = i_res;
            n_cnt = i_cnt;
        end else if (pop) begin
            for (int i = 0; i < MAX_RES - 1; i++) begin
                n_res[i] = r_res[i + 1];
            end
            n_cnt = r_cnt - t_cnt'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (r_cnt == '0 || (r_cnt == t_cnt'(1) && pop)))
        else $error("result buffer loaded while holding undelivered results");

    a_count_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !i_load) |=> (r_cnt == $past(r_cnt) - t_cnt'(1)))
        else $error("result count did not drop after a transfer");

    a_char_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_res[0].is_char) |-> (!r_res[0].line_end && !r_res[0].bad_line
                                               && !r_res[0].stream_done))
        else $error("character item carries marker flags");

    a_bad_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_res[0].bad_line) |-> r_res[0].line_end)
        else $error("bad line flag without line end");

endmodule

@@ hw/rtl/config_line_cleaner_unit.sv @@
// Top level of the configuration line cleaner: line state and per-byte step logic.
// The first result of a byte is offered in the cycle after its input transfer.
// Throughput: one byte per cycle while each byte yields at most one result and the
// output is ready; a byte with up to 3 results holds input until its last is sent.
// Any byte waits while a result is held and the output is not ready. Reset (synchronous,
// active low) returns the line state to its start values and empties the result buffer.
module config_line_cleaner_unit
    import clc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // in_byte
    input  logic       i_s_tuser,   // stream_end
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // out_char
    output logic       o_m_tlast,   // line_end
    output logic [2:0] o_m_tuser    // is_char, bad_line, stream_done
);

    t_state r_state;
    t_state n_state;
    t_step  step;
    logic   accept;
    logic   ready;

    assign o_s_tready = ready;
    assign accept     = i_s_tvalid && ready;
    assign step       = f_step(r_state, i_s_tdata, i_s_tuser);
    assign n_state    = accept ? step.st : r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RST;
        end else begin
            r_state <= n_state;
        end
    end

    clc_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_cnt      (step.cnt),
        .i_res      (step.res),
        .o_ready    (ready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

@@ bench/tb_config_line_cleaner_unit.sv @@
// Self-checking testbench for config_line_cleaner_unit: byte stream in, cleaned lines out.
`timescale 1ns / 1ps

module tb_config_line_cleaner_unit
    import clc_pkg::*;
();

    localparam int CYCLE_LIMIT = 60000;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_char;
        logic       line_end;
        logic       bad_line;
        logic       stream_done;
    } t_clean_item;

    class line_scoreboard;
        t_clean_item expected_q[$];
        int          errors;
        bit          cmt_open;
        bit          after_gap;
        bit          gap_owed;
        bit          line_used;
        bit          hash_line;
        bit          line_bad;
        bit          drop_next;
        logic [1:0]  held;
        int          step_n;

        function new();
            clear_line();
            drop_next = 1'b0;
            errors    = 0;
        endfunction

        function void clear_line();
            cmt_open   = 1'b0;
            after_gap  = 1'b1;
            gap_owed   = 1'b0;
            held       = HELD_NONE;
            line_used  = 1'b0;
            hash_line  = 1'b0;
            line_bad   = 1'b0;
        endfunction

        function void emit(logic [7:0] c, logic isc, logic le, logic bad);
            if (step_n < MAX_RES) begin
                expected_q.push_back('{c, isc, le, bad, 1'b0});
                step_n++;
            end
        endfunction

        // ordinary character, outside a two-byte token
        function void plain(logic [7:0] c);
            if (cmt_open) return;
            if (c == CH_SPACE || c == CH_TAB) begin
                if (!after_gap) begin
                    after_gap = 1'b1;
                    gap_owed  = 1'b1;
                end
            end else begin
                if (!line_used) begin
                    line_used = 1'b1;
                    hash_line = (c == CH_HASH);
                end
                if (!hash_line) begin
                    if (gap_owed) emit(CH_SPACE, 1'b1, 1'b0, 1'b0);
                    emit(c, 1'b1, 1'b0, 1'b0);
                end
                gap_owed  = 1'b0;
                after_gap = 1'b0;
            end
        endfunction

        function logic [7:0] held_byte();
            return (held == HELD_STAR) ? CH_STAR : CH_SLASH;
        endfunction

        function void fresh(logic [7:0] b);
            if (b == CH_SLASH) held = HELD_SLASH;
            else if (b == CH_STAR) held = HELD_STAR;
            else plain(b);
        endfunction

        function void take(logic [7:0] b);
            logic [7:0] prev;
            if (held == HELD_NONE) begin
                fresh(b);
            end else if (held == HELD_SLASH && b == CH_STAR) begin
                held     = HELD_NONE;
                cmt_open = 1'b1;
            end else if (held == HELD_STAR && b == CH_SLASH) begin
                held = HELD_NONE;
                if (cmt_open) cmt_open = 1'b0;
                else line_bad = 1'b1;
            end else begin
                prev = held_byte();
                held = HELD_NONE;
                plain(prev);
                fresh(b);
            end
        endfunction

        function void close_line();
            logic [7:0] prev;
            if (!line_bad && held != HELD_NONE) begin
                prev = held_byte();
                held = HELD_NONE;
                plain(prev);
            end
            if (cmt_open) line_bad = 1'b1;
            if (line_bad) emit(CH_NUL, 1'b0, 1'b1, 1'b1);
            else if (line_used && !hash_line) emit(CH_NUL, 1'b0, 1'b1, 1'b0);
            clear_line();
        endfunction

        function void note_input(logic [7:0] b, logic fin);
            t_clean_item last;
            step_n = 0;
            if (fin) begin
                close_line();
                if (step_n == 0) emit(CH_NUL, 1'b0, 1'b0, 1'b0);
                last = expected_q.pop_back();
                last.stream_done = 1'b1;
                expected_q.push_back(last);
                drop_next = 1'b0;
            end else if (drop_next) begin
                drop_next = 1'b0;
            end else if (b == CH_LF || b == CH_CR) begin
                close_line();
                drop_next = (b == CH_CR);
            end else if (!line_bad) begin
                take(b);
            end
        endfunction

        function void cmp(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check(logic [7:0] data, logic tlast, logic [2:0] tuser);
            t_clean_item want;
            if (expected_q.size() == 0) begin
                $error("result transfer with nothing expected: out_char %0h line_end %0b %s",
                       data, tlast, $sformatf("tuser %03b", tuser));
                errors++;
                return;
            end
            want = expected_q.pop_front();
            cmp("out_char", want.ch, data);
            cmp("is_char", {7'd0, want.is_char}, {7'd0, tuser[0]});
            cmp("line_end", {7'd0, want.line_end}, {7'd0, tlast});
            cmp("bad_line", {7'd0, want.bad_line}, {7'd0, tuser[1]});
            cmp("stream_done", {7'd0, want.stream_done}, {7'd0, tuser[2]});
        endfunction
    endclass

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic [7:0] i_s_tdata  = 8'h00;
    logic       i_s_tuser  = 1'b0;
    logic       i_m_tready = 1'b0;
    logic       o_s_tready;
    logic       o_m_tvalid;
    logic [7:0] o_m_tdata;
    logic       o_m_tlast;
    logic [2:0] o_m_tuser;

    line_scoreboard sb = new();
    int             cycles = 0;
    int             sent   = 0;
    bit             steady = 1'b0;

    config_line_cleaner_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) sb.check(o_m_tdata, o_m_tlast, o_m_tuser);
            if (i_s_tvalid && o_s_tready) sb.note_input(i_s_tdata, i_s_tuser);
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_config_line_cleaner_unit NOT OK");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_m_tready <= steady || ($urandom_range(99) >= 9);
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while (!steady && $urandom_range(99) < 9) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tuser  <= fin;
        do @(posedge i_clk); while (!o_s_tready);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic send_random_line();
        int n_tok;
        int pick;
        int k;
        n_tok = $urandom_range(0, 9);
        if ($urandom_range(99) < 12) send_byte(CH_HASH, 1'b0);
        for (k = 0; k < n_tok; k++) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                send_byte(8'($urandom_range(33, 126)), 1'b0);
            end else if (pick < 45) begin
                repeat ($urandom_range(1, 3))
                    send_byte($urandom_range(1) ? CH_SPACE : CH_TAB, 1'b0);
            end else if (pick < 60) begin
                send_byte(CH_SLASH, 1'b0);
                send_byte(CH_STAR, 1'b0);
                repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(32, 126)), 1'b0);
                if ($urandom_range(99) < 85) begin
                    send_byte(CH_STAR, 1'b0);
                    send_byte(CH_SLASH, 1'b0);
                end
            end else if (pick < 66) begin
                send_byte(CH_SLASH, 1'b0);
            end else if (pick < 72) begin
                send_byte(CH_STAR, 1'b0);
            end else if (pick < 76) begin
                send_byte(CH_STAR, 1'b0);
                send_byte(CH_SLASH, 1'b0);
            end else if (pick < 82) begin
                send_byte(CH_HASH, 1'b0);
            end else if (pick < 86) begin
                send_byte(CH_NUL, 1'b0);
            end else begin
                send_byte(8'($urandom), 1'b0);
            end
        end
        pick = $urandom_range(99);
        if (pick < 50) begin
            send_byte(CH_LF, 1'b0);
        end else if (pick < 70) begin
            send_byte(CH_CR, 1'b0);
        end else if (pick < 90) begin
            send_byte(CH_CR, 1'b0);
            send_byte(CH_LF, 1'b0);
        end else begin
            send_byte(8'($urandom), 1'b1);
        end
    endtask

    initial begin
        logic [7:0] opening[];
        opening = '{CH_NUL, 8'hFF, CH_SPACE, CH_TAB, CH_SLASH, CH_STAR, CH_SLASH, CH_STAR,
                    CH_STAR, CH_SLASH, CH_TAB, CH_STAR, 8'h61, CH_SPACE, CH_SLASH, CH_LF,
                    CH_STAR, CH_SLASH, 8'h62, CH_CR,
                    CH_LF, CH_HASH, 8'h63, CH_SLASH, CH_STAR, CH_CR,
                    8'h64, CH_LF, 8'h5A};
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (opening[i]) send_byte(opening[i], 1'b0);
        send_byte(8'hA5, 1'b1);
        send_byte(8'h00, 1'b1);
        while (sent < 210) begin
            steady = (sent >= 80 && sent < 130);
            send_random_line();
        end
        steady = 1'b0;
        send_byte(8'h00, 1'b1);
        i_s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("tb_config_line_cleaner_unit OK");
        end else begin
            $display("tb_config_line_cleaner_unit NOT OK");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/clc_pkg.sv
hw/rtl/clc_out_buf.sv
hw/rtl/config_line_cleaner_unit.sv
bench/tb_config_line_cleaner_unit.sv
